/* rtl/core/tpcq_pkg.sv */
package tpcq_pkg;

   // Configuration port geometry
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 16;

   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;
   typedef logic [CSR_DATA_WIDTH-1:0]  csr_data_type;

   // Register indexes
   localparam csr_index_type REG_DRAG_THRESHOLD = 3'd0;
   localparam csr_index_type REG_AREA_LEFT      = 3'd1;
   localparam csr_index_type REG_AREA_RIGHT     = 3'd2;
   localparam csr_index_type REG_AREA_TOP       = 3'd3;
   localparam csr_index_type REG_AREA_BOTTOM    = 3'd4;

   // Register reset values
   localparam csr_data_type RESET_DRAG_THRESHOLD = 16'd12;
   localparam csr_data_type RESET_AREA_EDGE      = 16'd0;

   // Touch event kinds; the two remaining codes are ignored
   localparam int KIND_WIDTH = 3;

   typedef enum logic [KIND_WIDTH-1:0] {
      KIND_PRESSED    = 3'd0,
      KIND_PRESSING   = 3'd1,
      KIND_RELEASED   = 3'd2,
      KIND_PRESS_LOST = 3'd3,
      KIND_LONG_PRESS = 3'd4,
      KIND_CLICKED    = 3'd5
   } kind_type;

endpackage

/* rtl/core/tpcq_channels.sv */
// Touch event channel
interface tpcq_req_if #(
   parameter int COORD_WIDTH = 16
);
   logic                                  valid;
   logic                                  ready;
   logic [tpcq_pkg::KIND_WIDTH-1:0]       kind;
   logic                                  point_valid;
   logic signed [COORD_WIDTH-1:0]         point_x;
   logic signed [COORD_WIDTH-1:0]         point_y;

   modport source (output valid, kind, point_valid, point_x, point_y, input ready);
   modport sink   (input valid, kind, point_valid, point_x, point_y, output ready);
endinterface

// Qualifier result channel
interface tpcq_rsp_if;
   logic valid;
   logic ready;
   logic clear_pressed;
   logic block_event;
   logic is_cancelled;

   modport source (output valid, clear_pressed, block_event, is_cancelled, input ready);
   modport sink   (input valid, clear_pressed, block_event, is_cancelled, output ready);
endinterface

// Register write channel
interface tpcq_csr_if;
   logic                          valid;
   logic                          ready;
   tpcq_pkg::csr_index_type       index;
   tpcq_pkg::csr_data_type        data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/touch_press_cancel_qualifier_unit.sv */
// Path: an accepted event beat is held in the input register and moves into the result
// register, from which its result beat is offered, once that register is free.
// Throughput: one event per cycle while the result side takes beats; an input register and a
// result register are separated by the combinational drag, area and flag logic.
// Reset (synchronous, active high) empties both registers, forgets the start
// point, clears the cancelled flag and restores the register defaults.
module touch_press_cancel_qualifier_unit #(
   parameter int COORD_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   tpcq_req_if.sink    req_if,
   tpcq_rsp_if.source  rsp_if,
   tpcq_csr_if.sink    csr_if
);
   import tpcq_pkg::*;

   // Difference of two coordinates needs one extra bit
   localparam int DiffWidth = COORD_WIDTH + 1;
   localparam int CmpWidth  = (DiffWidth > CSR_DATA_WIDTH) ? DiffWidth : CSR_DATA_WIDTH;
   localparam int AreaWidth = (COORD_WIDTH > CSR_DATA_WIDTH) ? COORD_WIDTH : CSR_DATA_WIDTH;

   // Configuration registers
   logic [CSR_DATA_WIDTH-1:0]        threshold_ff;
   logic signed [CSR_DATA_WIDTH-1:0] left_ff, right_ff, top_ff, bottom_ff;

   // Press state
   logic signed [COORD_WIDTH-1:0]    start_x_ff, start_x_in;
   logic signed [COORD_WIDTH-1:0]    start_y_ff, start_y_in;
   logic                             start_known_ff, start_known_in;
   logic                             cancel_ff, cancel_in;

   // Input register
   logic                             in_valid_ff, in_valid_in;
   logic [KIND_WIDTH-1:0]            in_kind_ff;
   logic                             in_point_valid_ff;
   logic signed [COORD_WIDTH-1:0]    in_x_ff, in_y_ff;

   // Result register
   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             clear_ff, clear_in;
   logic                             block_ff, block_in;
   logic                             cancelled_ff;

   // Handshake
   logic                             out_free;
   logic                             advance;
   logic                             req_accept;
   logic                             rsp_accept;

   // Qualification terms
   logic signed [DiffWidth-1:0]      diff_x, diff_y;
   logic [DiffWidth-1:0]             mag_x, mag_y;
   logic                             dragged;
   logic                             in_area;
   logic                             moved_off;
   logic signed [AreaWidth-1:0]      pos_x, pos_y;

   // Flow control: the input register moves on whenever the result register frees up
   assign out_free   = !rsp_valid_ff || rsp_if.ready;
   assign advance    = in_valid_ff && out_free;
   assign req_if.ready = !in_valid_ff || out_free;
   assign req_accept = req_if.valid && req_if.ready;
   assign rsp_accept = rsp_valid_ff && rsp_if.ready;

   assign in_valid_in  = req_accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_accept ? 1'b0 : rsp_valid_ff);

   // Per-axis distance from the start point
   assign diff_x = DiffWidth'(in_x_ff) - DiffWidth'(start_x_ff);
   assign diff_y = DiffWidth'(in_y_ff) - DiffWidth'(start_y_ff);
   assign mag_x  = diff_x[DiffWidth-1] ? DiffWidth'(-diff_x) : DiffWidth'(diff_x);
   assign mag_y  = diff_y[DiffWidth-1] ? DiffWidth'(-diff_y) : DiffWidth'(diff_y);

   assign dragged = start_known_ff && in_point_valid_ff &&
                    ((CmpWidth'(mag_x) >= CmpWidth'(threshold_ff)) ||
                     (CmpWidth'(mag_y) >= CmpWidth'(threshold_ff)));

   // Target rectangle test; an absent pointer is never inside
   assign pos_x  = AreaWidth'(in_x_ff);
   assign pos_y  = AreaWidth'(in_y_ff);
   assign in_area = in_point_valid_ff &&
                   (pos_x >= AreaWidth'(left_ff)) && (pos_x <= AreaWidth'(right_ff)) &&
                   (pos_y >= AreaWidth'(top_ff))  && (pos_y <= AreaWidth'(bottom_ff));

   assign moved_off = dragged || !in_area;

   // Event decode: next press state and result flags
   always_comb begin
      start_x_in     = start_x_ff;
      start_y_in     = start_y_ff;
      start_known_in = start_known_ff;
      cancel_in      = cancel_ff;
      clear_in       = 1'b0;
      block_in       = 1'b0;
      unique case (in_kind_ff)
         KIND_PRESSED: begin
            cancel_in      = 1'b0;
            start_known_in = in_point_valid_ff;
            if (in_point_valid_ff) begin
               start_x_in = in_x_ff;
               start_y_in = in_y_ff;
            end
         end
         KIND_PRESSING: begin
            if (moved_off) begin
               cancel_in = 1'b1;
               clear_in  = 1'b1;
            end
         end
         KIND_RELEASED: begin
            if (moved_off) begin
               cancel_in = 1'b1;
            end
            start_known_in = 1'b0;
            clear_in       = 1'b1;
         end
         KIND_PRESS_LOST: begin
            cancel_in      = 1'b1;
            start_known_in = 1'b0;
            clear_in       = 1'b1;
         end
         KIND_LONG_PRESS: begin
            if (cancel_ff || moved_off) begin
               cancel_in = 1'b1;
               clear_in  = 1'b1;
               block_in  = 1'b1;
            end
         end
         KIND_CLICKED: begin
            block_in       = cancel_ff || !in_area;
            cancel_in      = 1'b0;
            start_known_in = 1'b0;
            clear_in       = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Handshake control and press state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         start_x_ff     <= '0;
         start_y_ff     <= '0;
         start_known_ff <= 1'b0;
         cancel_ff      <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            start_x_ff     <= start_x_in;
            start_y_ff     <= start_y_in;
            start_known_ff <= start_known_in;
            cancel_ff      <= cancel_in;
         end
      end
   end

   // Event beat capture
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_kind_ff        <= req_if.kind;
         in_point_valid_ff <= req_if.point_valid;
         in_x_ff           <= req_if.point_x;
         in_y_ff           <= req_if.point_y;
      end
   end

   // Result beat capture
   always_ff @(posedge clock) begin
      if (advance) begin
         clear_ff     <= clear_in;
         block_ff     <= block_in;
         cancelled_ff <= cancel_in;
      end
   end

   // Register writes; unknown indexes are dropped
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= RESET_DRAG_THRESHOLD;
         left_ff      <= RESET_AREA_EDGE;
         right_ff     <= RESET_AREA_EDGE;
         top_ff       <= RESET_AREA_EDGE;
         bottom_ff    <= RESET_AREA_EDGE;
      end else if (csr_if.valid) begin
         unique case (csr_if.index)
            REG_DRAG_THRESHOLD: threshold_ff <= csr_if.data;
            REG_AREA_LEFT:      left_ff      <= csr_if.data;
            REG_AREA_RIGHT:     right_ff     <= csr_if.data;
            REG_AREA_TOP:       top_ff       <= csr_if.data;
            REG_AREA_BOTTOM:    bottom_ff    <= csr_if.data;
            default: begin
            end
         endcase
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.clear_pressed = clear_ff;
   assign rsp_if.block_event   = block_ff;
   assign rsp_if.is_cancelled  = cancelled_ff;

endmodule

/* rtl/core/tpcq_checker.sv */
module tpcq_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_clear_pressed,
   input logic rsp_block_event
);

   // Events in flight between the two channels
   logic [2:0] pending_ff, pending_in;
   logic       req_beat, rsp_beat;

   assign req_beat = req_valid && req_ready;
   assign rsp_beat = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff;
      if (req_beat && !rsp_beat) begin
         pending_in = pending_ff + 3'd1;
      end else if (rsp_beat && !req_beat) begin
         pending_in = pending_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // No result beat is offered straight after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat offered after reset");

   // A stalled result beat is not withdrawn
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat withdrawn while stalled");

   // Every result beat belongs to an event beat, and at most two are held
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || pending_ff != 3'd0) && pending_ff <= 3'd2)
      else $error("result beats out of step with event beats");

   // A blocked long press or click always removes the pressed state as well
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_block_event |-> rsp_clear_pressed)
      else $error("event blocked without clearing the pressed state");

endmodule

bind touch_press_cancel_qualifier_unit tpcq_checker u_tpcq_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_if.valid),
   .req_ready         (req_if.ready),
   .rsp_valid         (rsp_if.valid),
   .rsp_ready         (rsp_if.ready),
   .rsp_clear_pressed (rsp_if.clear_pressed),
   .rsp_block_event   (rsp_if.block_event)
);

/* tb/touch_press_cancel_qualifier_unit_tb.sv */
module touch_press_cancel_qualifier_unit_tb;
   import tpcq_pkg::*;

   localparam int COORD_WIDTH      = 16;
   localparam int COORD_MIN        = -(2 ** (COORD_WIDTH - 1));
   localparam int COORD_MAX        = 2 ** (COORD_WIDTH - 1) - 1;
   localparam int RESULT_LATENCY   = 2;
   localparam int CYCLE_LIMIT      = 200000;
   localparam int RANDOM_PHASES    = 8;
   localparam int EVENTS_PER_PHASE = 220;
   localparam int HOLD_OFF_CYCLES  = 300;

   // The two event codes that the block must ignore
   localparam logic [KIND_WIDTH-1:0] KIND_SPARE_A = 3'd6;
   localparam logic [KIND_WIDTH-1:0] KIND_SPARE_B = 3'd7;

   typedef struct {
      logic [KIND_WIDTH-1:0]         kind;
      logic                          point_valid;
      logic signed [COORD_WIDTH-1:0] point_x;
      logic signed [COORD_WIDTH-1:0] point_y;
   } touch_event_type;

   typedef struct packed {
      logic clear_pressed;
      logic block_event;
      logic is_cancelled;
   } verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tpcq_req_if #(.COORD_WIDTH(COORD_WIDTH)) req_if ();
   tpcq_rsp_if rsp_if ();
   tpcq_csr_if csr_if ();

   touch_press_cancel_qualifier_unit #(.COORD_WIDTH(COORD_WIDTH)) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // Clock with a period of 12 units.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Shadow copy of the registers and of the press tracking state.
   int drag_limit;
   int rect_left, rect_right, rect_top, rect_bottom;
   int anchor_x, anchor_y;
   bit anchor_known;
   bit cancelled;

   touch_event_type pending_events[$];
   verdict_type     expected_verdicts[$];

   bit beat_taken;
   int send_idle_pct;
   int recv_stall_pct;
   int hold_left;
   int cycle_count;
   int mismatches;
   int results_checked;
   int events_accepted;
   int writes_done;
   int settings_used;
   int kind_seen [2 ** KIND_WIDTH];

   task automatic report_mismatch(string what);
      $display("MISMATCH on result %0d: %s", results_checked, what);
      mismatches++;
   endtask

   task automatic check_field(string name, logic got, logic want);
      if (got !== want) begin
         report_mismatch($sformatf("%s is %b, expected %b", name, got, want));
      end
   endtask

   function automatic int clamp_coord(int v);
      if (v < COORD_MIN) return COORD_MIN;
      if (v > COORD_MAX) return COORD_MAX;
      return v;
   endfunction

   // A drag needs a known start point and a present pointer.
   function automatic bit moved_too_far(bit pv, int x, int y);
      int dx, dy;
      if (!anchor_known || !pv) return 1'b0;
      dx = x - anchor_x;
      dy = y - anchor_y;
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      return (dx >= drag_limit) || (dy >= drag_limit);
   endfunction

   // A missing pointer is never inside; an empty rectangle holds no point.
   function automatic bit inside_target(bit pv, int x, int y);
      if (!pv) return 1'b0;
      return x >= rect_left && x <= rect_right && y >= rect_top && y <= rect_bottom;
   endfunction

   // Works out the outcome of one event and advances the tracking state.
   function automatic verdict_type qualify_event(touch_event_type ev);
      verdict_type v;
      int x, y;
      bit drag_or_out;
      v = '0;
      x = ev.point_x;
      y = ev.point_y;
      drag_or_out = moved_too_far(ev.point_valid, x, y) ||
                    !inside_target(ev.point_valid, x, y);
      case (ev.kind)
         KIND_PRESSED: begin
            cancelled = 1'b0;
            anchor_known = ev.point_valid;
            if (ev.point_valid) begin
               anchor_x = x;
               anchor_y = y;
            end
         end
         KIND_PRESSING: begin
            if (drag_or_out) begin
               cancelled = 1'b1;
               v.clear_pressed = 1'b1;
            end
         end
         KIND_RELEASED: begin
            if (drag_or_out) cancelled = 1'b1;
            anchor_known = 1'b0;
            v.clear_pressed = 1'b1;
         end
         KIND_PRESS_LOST: begin
            cancelled = 1'b1;
            anchor_known = 1'b0;
            v.clear_pressed = 1'b1;
         end
         KIND_LONG_PRESS: begin
            if (cancelled || drag_or_out) begin
               cancelled = 1'b1;
               v.clear_pressed = 1'b1;
               v.block_event = 1'b1;
            end
         end
         KIND_CLICKED: begin
            v.block_event = cancelled || !inside_target(ev.point_valid, x, y);
            cancelled = 1'b0;
            anchor_known = 1'b0;
            v.clear_pressed = 1'b1;
         end
         default: begin
         end
      endcase
      v.is_cancelled = cancelled;
      return v;
   endfunction

   function automatic void add_event(logic [KIND_WIDTH-1:0] kind, bit pv, int x, int y);
      touch_event_type ev;
      ev.kind = kind;
      ev.point_valid = pv;
      ev.point_x = x[COORD_WIDTH-1:0];
      ev.point_y = y[COORD_WIDTH-1:0];
      pending_events.push_back(ev);
   endfunction

   // Picks a coordinate near an edge, inside the span, anywhere, or at an extreme.
   function automatic int pick_coord(int lo, int hi);
      int a, b;
      logic signed [COORD_WIDTH-1:0] raw;
      a = (lo < hi) ? lo : hi;
      b = (lo < hi) ? hi : lo;
      raw = COORD_WIDTH'($urandom);
      case ($urandom_range(5))
         0: return clamp_coord(lo + int'($urandom_range(6)) - 3);
         1: return clamp_coord(hi + int'($urandom_range(6)) - 3);
         2, 3: return a + int'($urandom_range(b - a));
         4: return int'(raw);
         default: return ($urandom_range(1) == 1) ? COORD_MAX : COORD_MIN;
      endcase
   endfunction

   // Moves a coordinate by about the drag threshold (at most 2000), often right at its boundary.
   function automatic int drift(int base);
      int reach;
      reach = (drag_limit > 2000) ? 2000 : drag_limit;
      case ($urandom_range(3))
         0: return clamp_coord(base + (($urandom_range(1) == 1) ? reach : -reach));
         1: return clamp_coord(base + (($urandom_range(1) == 1) ? reach - 1 : 1 - reach));
         default: return clamp_coord(base + int'($urandom_range(2 * reach + 4)) - reach - 2);
      endcase
   endfunction

   // A press, some moves, and one of the usual endings or none at all.
   function automatic void add_gesture();
      int sx, sy, n;
      bit pv;
      pv = ($urandom_range(9) != 0);
      sx = pick_coord(rect_left, rect_right);
      sy = pick_coord(rect_top, rect_bottom);
      add_event(KIND_PRESSED, pv, sx, sy);
      n = $urandom_range(5);
      repeat (n) begin
         if ($urandom_range(7) == 0) begin
            add_event(KIND_LONG_PRESS, $urandom_range(9) != 0, drift(sx), drift(sy));
         end else if ($urandom_range(7) == 0) begin
            add_event(KIND_PRESSING, $urandom_range(9) != 0,
                      pick_coord(rect_left, rect_right), pick_coord(rect_top, rect_bottom));
         end else begin
            add_event(KIND_PRESSING, $urandom_range(9) != 0, drift(sx), drift(sy));
         end
      end
      case ($urandom_range(9))
         0, 1, 2: add_event(KIND_RELEASED, $urandom_range(9) != 0, drift(sx), drift(sy));
         3, 4, 5: add_event(KIND_CLICKED, $urandom_range(9) != 0, drift(sx), drift(sy));
         6: add_event(KIND_PRESS_LOST, $urandom_range(1) == 1, drift(sx), drift(sy));
         7: begin
            add_event(KIND_LONG_PRESS, 1'b1, sx, sy);
            add_event(KIND_CLICKED, 1'b1, sx, sy);
         end
         8: add_event(($urandom_range(1) == 1) ? KIND_SPARE_A : KIND_SPARE_B,
                      $urandom_range(1) == 1, drift(sx), drift(sy));
         default: begin
         end
      endcase
   endfunction

   // Unrelated event with every field drawn over its full range.
   function automatic void add_noise();
      logic signed [COORD_WIDTH-1:0] rx, ry;
      rx = COORD_WIDTH'($urandom);
      ry = COORD_WIDTH'($urandom);
      add_event(KIND_WIDTH'($urandom_range(7)), $urandom_range(1) == 1, int'(rx), int'(ry));
   endfunction

   task automatic write_register(csr_index_type idx, csr_data_type value);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      case (idx)
         REG_DRAG_THRESHOLD: drag_limit  = value;
         REG_AREA_LEFT:      rect_left   = $signed(value);
         REG_AREA_RIGHT:     rect_right  = $signed(value);
         REG_AREA_TOP:       rect_top    = $signed(value);
         REG_AREA_BOTTOM:    rect_bottom = $signed(value);
         default: begin
         end
      endcase
      writes_done++;
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic program_target(int thr, int l, int r, int t, int b);
      write_register(REG_DRAG_THRESHOLD, csr_data_type'(thr));
      write_register(REG_AREA_LEFT, csr_data_type'(l));
      write_register(REG_AREA_RIGHT, csr_data_type'(r));
      write_register(REG_AREA_TOP, csr_data_type'(t));
      write_register(REG_AREA_BOTTOM, csr_data_type'(b));
      settings_used++;
   endtask

   // Lets the queued events run under the given idling, then waits until all is quiet.
   task automatic run_phase(int send_idle, int recv_stall, int hold);
      send_idle_pct = send_idle;
      recv_stall_pct = recv_stall;
      hold_left = hold;
      while (pending_events.size() > 0 || req_if.valid || expected_verdicts.size() > 0) begin
         @(posedge clock);
      end
      repeat (RESULT_LATENCY + 2) @(posedge clock);
   endtask

   // Event driver: a new beat is offered at the falling edge once the last one went.
   always @(negedge clock) begin
      touch_event_type ev;
      if (!reset && (!req_if.valid || beat_taken)) begin
         beat_taken = 1'b0;
         if (pending_events.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            ev = pending_events.pop_front();
            req_if.valid       <= 1'b1;
            req_if.kind        <= ev.kind;
            req_if.point_valid <= ev.point_valid;
            req_if.point_x     <= ev.point_x;
            req_if.point_y     <= ev.point_y;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Long hold-off of the result side, counted down in cycles.
   always @(negedge clock) begin
      if (hold_left > 0) hold_left <= hold_left - 1;
   end

   // Result side back-pressure.
   always @(negedge clock) begin
      rsp_if.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
   end

   // Monitor: checks result beats, then predicts the outcome of each accepted event.
   always @(posedge clock) begin
      touch_event_type got_event;
      verdict_type want;
      cycle_count++;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_verdicts.size() == 0) begin
               report_mismatch("result beat arrived with nothing expected");
            end else begin
               want = expected_verdicts.pop_front();
               check_field("clear_pressed", rsp_if.clear_pressed, want.clear_pressed);
               check_field("block_event", rsp_if.block_event, want.block_event);
               check_field("is_cancelled", rsp_if.is_cancelled, want.is_cancelled);
            end
            results_checked++;
         end
         if (req_if.valid && req_if.ready) begin
            got_event.kind        = req_if.kind;
            got_event.point_valid = req_if.point_valid;
            got_event.point_x     = req_if.point_x;
            got_event.point_y     = req_if.point_y;
            kind_seen[req_if.kind]++;
            expected_verdicts.push_back(qualify_event(got_event));
            events_accepted++;
            beat_taken = 1'b1;
         end
      end
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Run stopped by the cycle limit after %0d cycles.", cycle_count);
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      int thr, l, r, t, b, w;
      req_if.valid       = 1'b0;
      req_if.kind        = KIND_PRESSED;
      req_if.point_valid = 1'b0;
      req_if.point_x     = '0;
      req_if.point_y     = '0;
      rsp_if.ready       = 1'b0;
      csr_if.valid       = 1'b0;
      csr_if.index       = REG_DRAG_THRESHOLD;
      csr_if.data        = '0;
      send_idle_pct      = 0;
      recv_stall_pct     = 0;
      hold_left          = 0;

      // Registers and tracking state as they stand after reset.
      drag_limit   = RESET_DRAG_THRESHOLD;
      rect_left    = $signed(RESET_AREA_EDGE);
      rect_right   = $signed(RESET_AREA_EDGE);
      rect_top     = $signed(RESET_AREA_EDGE);
      rect_bottom  = $signed(RESET_AREA_EDGE);
      anchor_x     = 0;
      anchor_y     = 0;
      anchor_known = 1'b0;
      cancelled    = 1'b0;
      settings_used = 1;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed events against the reset registers, a one-point target at the origin.
      add_event(KIND_SPARE_A, 1'b1, 0, 0);
      add_event(KIND_PRESSING, 1'b1, 0, 0);
      add_event(KIND_PRESSED, 1'b0, 0, 0);
      add_event(KIND_PRESSING, 1'b0, 0, 0);
      add_event(KIND_LONG_PRESS, 1'b1, 0, 0);
      add_event(KIND_CLICKED, 1'b1, 0, 0);
      add_event(KIND_PRESSED, 1'b1, 0, 0);
      add_event(KIND_LONG_PRESS, 1'b1, 0, 0);
      add_event(KIND_CLICKED, 1'b1, 0, 0);
      add_event(KIND_PRESSED, 1'b1, 0, 0);
      add_event(KIND_RELEASED, 1'b1, 0, 0);
      add_event(KIND_PRESSED, 1'b1, 0, 0);
      add_event(KIND_PRESS_LOST, 1'b1, 0, 0);
      add_event(KIND_SPARE_B, 1'b0, COORD_MAX, COORD_MIN);
      add_event(KIND_PRESSED, 1'b1, 0, 0);
      add_event(KIND_RELEASED, 1'b0, 0, 0);
      run_phase(0, 0, 0);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         // Register settings: zero and full threshold, an empty target, then random ones.
         case (p)
            0: program_target(0, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);
            1: program_target(65535, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);
            2: program_target(12, 100, 99, -50, 50);
            default: begin
               if (p == 5) begin
                  for (int i = REG_AREA_BOTTOM + 1; i < 2 ** CSR_INDEX_WIDTH; i++) begin
                     write_register(csr_index_type'(i), csr_data_type'($urandom));
                  end
               end
               thr = (p == 4) ? 1 : $urandom_range(80, 2);
               l = pick_coord(COORD_MIN, COORD_MAX);
               w = $urandom_range(3000);
               r = clamp_coord(l + w);
               t = pick_coord(COORD_MIN, COORD_MAX);
               w = $urandom_range(3000);
               b = clamp_coord(t + w);
               program_target(thr, l, r, t, b);
            end
         endcase

         // A few directed events at the extreme settings.
         case (p)
            0: begin
               add_event(KIND_PRESSED, 1'b1, COORD_MIN, COORD_MIN);
               add_event(KIND_PRESSING, 1'b1, COORD_MIN, COORD_MIN);
               add_event(KIND_PRESSED, 1'b0, COORD_MAX, COORD_MAX);
               add_event(KIND_PRESSING, 1'b0, COORD_MAX, COORD_MAX);
            end
            1: begin
               add_event(KIND_PRESSED, 1'b1, COORD_MIN, COORD_MIN);
               add_event(KIND_PRESSING, 1'b1, COORD_MAX - 1, COORD_MIN);
               add_event(KIND_PRESSING, 1'b1, COORD_MAX, COORD_MIN);
            end
            2: begin
               add_event(KIND_PRESSED, 1'b1, 100, 0);
               add_event(KIND_PRESSING, 1'b1, 100, 0);
               add_event(KIND_CLICKED, 1'b1, 99, 0);
            end
            default: begin
            end
         endcase

         while (pending_events.size() < EVENTS_PER_PHASE) begin
            if ($urandom_range(6) == 0) add_noise();
            else add_gesture();
         end

         // Idling pattern rotates; one phase runs flat out against a long hold-off.
         case (p % 4)
            0: run_phase(0, 0, (p == 4) ? HOLD_OFF_CYCLES : 0);
            1: run_phase(59, 0, 0);
            2: run_phase(0, 59, 0);
            default: run_phase(34, 34, 0);
         endcase
      end

      $display("Covered %0d events under %0d register settings: pressed %0d, pressing %0d,",
               events_accepted, settings_used, kind_seen[KIND_PRESSED],
               kind_seen[KIND_PRESSING]);
      $display("released %0d, lost %0d, long %0d, clicked %0d, ignored %0d;",
               kind_seen[KIND_RELEASED], kind_seen[KIND_PRESS_LOST],
               kind_seen[KIND_LONG_PRESS], kind_seen[KIND_CLICKED],
               kind_seen[KIND_SPARE_A] + kind_seen[KIND_SPARE_B]);
      $display("%0d results checked and %0d register writes made.",
               results_checked, writes_done);
      if (mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
